/* rtl/core/pac_pkg.sv */
// ----------------------------------------------------------------------------
// pac_pkg: shared types and constants of the particulate AQI calculator
// Payload structs, breakpoint tables with their reciprocal divisors, segment
// bases and quality level codes.
// ----------------------------------------------------------------------------
package pac_pkg;

	// Payload of one input transfer
	typedef struct packed {
		logic [15:0] pm25_concentration;
		logic [15:0] pm10_concentration;
	} pac_sample_t;

	// Payload of one result transfer
	typedef struct packed {
		logic [15:0] air_index;
		logic [2:0]  quality_level;
	} pac_result_t;

	// Quality level codes
	localparam logic [2:0] QL_VERY_LOW  = 3'd0;
	localparam logic [2:0] QL_LOW       = 3'd1;
	localparam logic [2:0] QL_MEDIUM    = 3'd2;
	localparam logic [2:0] QL_HIGH      = 3'd3;
	localparam logic [2:0] QL_VERY_HIGH = 3'd4;

	// Quality thresholds on the index
	localparam logic [15:0] QT_LOW       = 16'd25;
	localparam logic [15:0] QT_MEDIUM    = 16'd50;
	localparam logic [15:0] QT_HIGH      = 16'd75;
	localparam logic [15:0] QT_VERY_HIGH = 16'd100;

	// Largest index the arithmetic can produce (full-scale PM10)
	localparam logic [15:0] INDEX_MAX = 16'd46757;

	localparam int SEGMENTS = 5;
	localparam int SEG_W    = $clog2(SEGMENTS);
	localparam int BP_W     = 10;   // doubled breakpoints stay below 1024
	localparam int C2_W     = 17;   // doubled 16-bit concentration
	localparam int RCP_SH   = 25;   // reciprocal scale, exact for diff < 2^17
	localparam int RCP_W    = 27;

	// 50 * 2^RCP_SH; reciprocal for divisor d is ceil(RcpScale / d)
	localparam logic [63:0] RcpScale = 64'd50 << RCP_SH;

	typedef logic [SEG_W-1:0] pac_seg_t;

	// One breakpoint table: doubled breakpoints and per-segment reciprocals
	typedef struct packed {
		logic [SEGMENTS:0][BP_W-1:0]    bp;
		logic [SEGMENTS-1:0][RCP_W-1:0] rcp;
	} pac_table_t;

	// Segment bases 0, 50, 100, 150, 200
	localparam logic [SEGMENTS-1:0][7:0] SEG_BASE =
		{8'd200, 8'd150, 8'd100, 8'd50, 8'd0};

	// PM2.5: 0, 9.0, 35.5, 55.5, 125.5, 225.5 (doubled); spans 18,53,40,140,200
	localparam pac_table_t TBL_PM25 = '{
		bp:  {10'd451, 10'd251, 10'd111, 10'd71, 10'd18, 10'd0},
		rcp: {27'((RcpScale + 64'd199) / 64'd200),
		      27'((RcpScale + 64'd139) / 64'd140),
		      27'((RcpScale + 64'd39)  / 64'd40),
		      27'((RcpScale + 64'd52)  / 64'd53),
		      27'((RcpScale + 64'd17)  / 64'd18)}
	};

	// PM10: 0, 55, 155, 255, 355, 425 (doubled); spans 110,200,200,200,140
	localparam pac_table_t TBL_PM10 = '{
		bp:  {10'd850, 10'd710, 10'd510, 10'd310, 10'd110, 10'd0},
		rcp: {27'((RcpScale + 64'd139) / 64'd140),
		      27'((RcpScale + 64'd199) / 64'd200),
		      27'((RcpScale + 64'd199) / 64'd200),
		      27'((RcpScale + 64'd199) / 64'd200),
		      27'((RcpScale + 64'd109) / 64'd110)}
	};

endpackage

/* rtl/core/pac_stream_if.sv */
// ----------------------------------------------------------------------------
// pac_stream_if: valid/ready stream channel
// Carries one payload per transfer; a transfer completes on a rising clock
// edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface pac_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/pac_sub_index.sv */
// ----------------------------------------------------------------------------
// pac_sub_index: piecewise-linear sub-index of one concentration
// Picks the breakpoint segment, then computes base + floor(50*(2c-lo)/span)
// with one multiply by a precomputed exact reciprocal.
// ----------------------------------------------------------------------------
module pac_sub_index
	import pac_pkg::*;
(
	input  logic [15:0] conc,
	input  pac_table_t  tbl,
	output logic [15:0] sub_index
);

	logic [C2_W-1:0]        c2;
	pac_seg_t               seg;
	logic [C2_W-1:0]        diff;
	logic [C2_W+RCP_W-1:0]  prod;
	logic [15:0]            quot;

	assign c2 = {conc, 1'b0};

	// Segment search: lowest breakpoint the value is below; top segment otherwise
	always_comb begin
		seg = SEG_W'(SEGMENTS - 1);
		for (int i = SEGMENTS - 1; i >= 1; i--) begin
			if (c2 < C2_W'(tbl.bp[i])) begin
				seg = SEG_W'(i - 1);
			end
		end
	end

	// Offset into segment, scaled divide via reciprocal (exact for 17-bit offsets)
	assign diff = c2 - C2_W'(tbl.bp[seg]);
	assign prod = (C2_W+RCP_W)'(diff) * (C2_W+RCP_W)'(tbl.rcp[seg]);
	assign quot = prod[RCP_SH+15:RCP_SH];

	assign sub_index = quot + 16'(SEG_BASE[seg]);

endmodule

/* rtl/core/particulate_aqi_calculator.sv */
// ----------------------------------------------------------------------------
// particulate_aqi_calculator: PM2.5/PM10 air quality index
// Two-stage stream block: concentration pair in, index and quality level out.
// ----------------------------------------------------------------------------
// Accepts one concentration pair per clock while the output is taken and returns
// one result per pair, passing through stage 1 and the result register. Stage 1
// registers the pair; between stage 1 and the result register each channel
// runs its segment search and a single 17x27 reciprocal multiply, followed by
// the max of the two sub-indices and the quality thresholds. Both stages hold
// under backpressure, so throughput is one item per clock while the output is
// taken. There is no configuration and no state beyond the pipeline.
module particulate_aqi_calculator
	import pac_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	pac_stream_if.sink   samples,
	pac_stream_if.source results
);

	logic        valid_s1;
	logic [15:0] pm25_s1;
	logic [15:0] pm10_s1;
	logic        valid_s2;
	pac_result_t result_s2;

	logic        adv_s1;
	logic        adv_s2;
	logic [15:0] sub25;
	logic [15:0] sub10;
	logic [15:0] index_max;
	logic [2:0]  level;

	// Pipeline advance: each stage moves when the next one frees up
	assign adv_s2          = !valid_s2 || results.ready;
	assign adv_s1          = !valid_s1 || adv_s2;
	assign samples.ready   = adv_s1;
	assign results.valid   = valid_s2;
	assign results.payload = result_s2;

	// Stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && samples.valid) begin
			pm25_s1 <= samples.payload.pm25_concentration;
			pm10_s1 <= samples.payload.pm10_concentration;
		end
	end

	// Sub-indices of both channels
	pac_sub_index u_sub_pm25 (
		.conc      (pm25_s1),
		.tbl       (TBL_PM25),
		.sub_index (sub25)
	);

	pac_sub_index u_sub_pm10 (
		.conc      (pm10_s1),
		.tbl       (TBL_PM10),
		.sub_index (sub10)
	);

	// Larger sub-index and its quality class
	assign index_max = (sub25 > sub10) ? sub25 : sub10;

	always_comb begin
		if (index_max < QT_LOW) begin
			level = QL_VERY_LOW;
		end else if (index_max < QT_MEDIUM) begin
			level = QL_LOW;
		end else if (index_max < QT_HIGH) begin
			level = QL_MEDIUM;
		end else if (index_max < QT_VERY_HIGH) begin
			level = QL_HIGH;
		end else begin
			level = QL_VERY_HIGH;
		end
	end

	// Stage 2: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2.air_index     <= index_max;
			result_s2.quality_level <= level;
		end
	end

`ifndef NO_ASSERTIONS
	// Full pipeline with stalled output must not take a new transfer
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !results.ready) |-> !samples.ready)
		else $error("input accepted while pipeline full and stalled");

	// Quality level agrees with the index it was derived from
	a_level_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((result_s2.air_index < QT_LOW) ==
		              (result_s2.quality_level == QL_VERY_LOW)) &&
		             ((result_s2.air_index >= QT_VERY_HIGH) ==
		              (result_s2.quality_level == QL_VERY_HIGH)))
		else $error("quality level does not match air index");

	// Index never exceeds the full-scale bound
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (result_s2.air_index <= INDEX_MAX))
		else $error("air index above full-scale bound");

	// A stage-1 item with a free result stage lands there on the next edge
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> valid_s2)
		else $error("stage 1 item lost");
`endif

endmodule
